### sv/apr_pkg.sv
// Package for the aging page replacement block.
// Holds sizes, register indexes, cell commands and the structs shared by the cell row.
// No dependencies.
`default_nettype none
package apr_pkg;
   localparam int FRAMES    = 64;
   localparam int PAGE_BITS = 16;
   localparam int AGE_BITS  = 32;
   localparam int IDX_BITS  = $clog2(FRAMES);
   localparam int USED_BITS = $clog2(FRAMES + 1);
   localparam int GRP_BITS  = $clog2(AGE_BITS / 4);

   localparam logic [7:0] CSR_SHIFT_INTERVAL = 8'd0;
   localparam logic [7:0] CSR_REGISTER_BITS  = 8'd1;
   localparam logic [7:0] SHIFT_RESET        = 8'd10;
   localparam logic [5:0] BITS_RESET         = 6'd8;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE,
      CELL_HIT,
      CELL_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic                 dirty;
      logic [AGE_BITS-1:0]  age;
   } cell_entry_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic                 wr;
      logic [AGE_BITS-1:0]  top;
      logic [AGE_BITS-1:0]  amask;
   } cell_bus_type;
endpackage
`default_nettype wire

### sv/aging_page_replacement_top.sv
// Aging page replacement over a row of frame cells.
//
// A page reference is a transfer on req_ (page number and write flag). One result per
// reference leaves on rsp_: hit, eviction, write-back and the saturating totals. csr_ready
// is always high and unknown indexes are ignored. Configuration (shift interval, age width)
// must be written over csr_ only while the block is idle; the block does not enforce this.
//
// Frames are kept in insertion order along the row, oldest in cell 0; an eviction closes
// the row up by one and appends the new page at the end.
// A hit or a fill of a free frame passes through LOOK and FINISH; the result register
// is loaded on leaving FINISH, and the next reference is taken back in IDLE.
// A fault with all frames in use runs a minimum search over the ages in SEARCH, 4 age
// bits per cycle, then evicts in EVICT before FINISH. A new reference is taken only
// once the previous one has reached the result register. Reset clears the counters,
// the frame count and the configuration to 10 and 8; frame contents need no clearing.
// A stalled receiver holds the result register; a new reference is taken meanwhile,
// and its result waits until the previous one is taken.
`default_nettype none
module aging_page_replacement_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [apr_pkg::PAGE_BITS-1:0] req_page_number,
   input  wire logic                          req_write_access,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic                               rsp_evicted_valid,
   output logic [apr_pkg::PAGE_BITS-1:0]      rsp_evicted_page,
   output logic                               rsp_write_back,
   output logic [31:0]                        rsp_fault_total,
   output logic [31:0]                        rsp_writeback_total,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [7:0]                    csr_index,
   input  wire logic [7:0]                    csr_wdata
);
   localparam int F = apr_pkg::FRAMES;
   localparam int IDX_W = apr_pkg::IDX_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOK   = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_EVICT  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] interval_ff, interval_in;
   logic [5:0] bits_ff, bits_in;
   logic [7:0] tick_ff, tick_in;
   logic [apr_pkg::USED_BITS-1:0] used_ff, used_in;
   logic [31:0] faults_ff, faults_in, wbs_ff, wbs_in;
   logic [apr_pkg::PAGE_BITS-1:0] page_ff, page_in;
   logic wr_ff, wr_in;
   logic [F-1:0] cand_ff, cand_in;
   logic [apr_pkg::GRP_BITS-1:0] grp_ff, grp_in;
   logic hit_ff, hit_in, evv_ff, evv_in, wb_ff, wb_in;
   logic [apr_pkg::PAGE_BITS-1:0] evp_ff, evp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_evv_ff, rsp_wb_ff;
   logic [apr_pkg::PAGE_BITS-1:0] rsp_evp_ff;
   logic [31:0] rsp_faults_ff, rsp_wbs_ff;
   logic rsp_load;

   apr_pkg::cell_cmd_type   cmd [F];
   apr_pkg::cell_entry_type entry [F];
   apr_pkg::cell_entry_type upper [F];
   logic [F-1:0] match, valid;
   apr_pkg::cell_bus_type bus;

   logic [5:0] n;
   logic [F-1:0] cand_step, zero_vec;
   logic [IDX_W-1:0] victim;
   logic [F-1:0] vic_onehot;
   logic [apr_pkg::PAGE_BITS-1:0] vic_page;
   logic vic_dirty;
   logic [4:0] bit_sel;

   // Effective age width: 0 acts as 1, above 32 as 32.
   always_comb begin
      if (bits_ff == 6'd0) begin
         n = 6'd1;
      end else if (bits_ff > 6'd32) begin
         n = 6'd32;
      end else begin
         n = bits_ff;
      end
      bus.page  = page_ff;
      bus.wr    = wr_ff;
      bus.top   = 32'd1 << (n - 6'd1);
      bus.amask = (n == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
   end

   for (genvar i = 0; i < F; i++) begin : g_cell
      assign valid[i] = (apr_pkg::USED_BITS'(i) < used_ff);
      if (i == F - 1) begin : g_last
         assign upper[i] = '0;
      end else begin : g_mid
         assign upper[i] = entry[i+1];
      end
      apr_cell u_cell (
         .clock (clock),
         .cmd   (cmd[i]),
         .bus   (bus),
         .upper (upper[i]),
         .valid (valid[i]),
         .entry (entry[i]),
         .match (match[i])
      );
   end

   // Four age bits per cycle, most significant first: drop candidates with a one
   // wherever some candidate has a zero.
   always_comb begin
      cand_step = cand_ff;
      for (int j = 3; j >= 0; j--) begin
         bit_sel = {grp_ff, 2'(j)};
         for (int i = 0; i < F; i++) begin
            zero_vec[i] = cand_step[i] & ~entry[i].age[bit_sel];
         end
         if (|zero_vec) begin
            cand_step = zero_vec;
         end
      end
   end

   // Lowest surviving cell is the oldest insertion among equal ages.
   always_comb begin
      victim = '0;
      for (int i = F - 1; i >= 0; i--) begin
         if (cand_ff[i]) begin
            victim = IDX_W'(i);
         end
      end
      vic_page  = '0;
      vic_dirty = 1'b0;
      for (int i = 0; i < F; i++) begin
         vic_onehot[i] = (victim == IDX_W'(i));
         if (vic_onehot[i]) begin
            vic_page  = vic_page | entry[i].page;
            vic_dirty = vic_dirty | entry[i].dirty;
         end
      end
   end

   assign rsp_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      bits_in      = bits_ff;
      tick_in      = tick_ff;
      used_in      = used_ff;
      faults_in    = faults_ff;
      wbs_in       = wbs_ff;
      page_in      = page_ff;
      wr_in        = wr_ff;
      cand_in      = cand_ff;
      grp_in       = grp_ff;
      hit_in       = hit_ff;
      evv_in       = evv_ff;
      evp_in       = evp_ff;
      wb_in        = wb_ff;
      rsp_valid_in = rsp_valid_ff;
      for (int i = 0; i < F; i++) begin
         cmd[i] = apr_pkg::CELL_HOLD;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         if (csr_index == apr_pkg::CSR_SHIFT_INTERVAL) begin
            interval_in = csr_wdata;
         end else if (csr_index == apr_pkg::CSR_REGISTER_BITS) begin
            bits_in = csr_wdata[5:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in  = req_page_number;
               wr_in    = req_write_access;
               tick_in  = tick_ff + 8'd1;
               hit_in   = 1'b0;
               evv_in   = 1'b0;
               evp_in   = '0;
               wb_in    = 1'b0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (|match) begin
               hit_in = 1'b1;
               for (int i = 0; i < F; i++) begin
                  if (match[i]) begin
                     cmd[i] = apr_pkg::CELL_HIT;
                  end
               end
               state_in = ST_FINISH;
            end else begin
               if (faults_ff != 32'hFFFF_FFFF) begin
                  faults_in = faults_ff + 32'd1;
               end
               if (used_ff < apr_pkg::USED_BITS'(F)) begin
                  for (int i = 0; i < F; i++) begin
                     if (apr_pkg::USED_BITS'(i) == used_ff) begin
                        cmd[i] = apr_pkg::CELL_LOAD;
                     end
                  end
                  used_in  = used_ff + 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  cand_in  = '1;
                  grp_in   = '1;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cand_in = cand_step;
            grp_in  = grp_ff - 1'b1;
            if (grp_ff == '0) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            evv_in = 1'b1;
            evp_in = vic_page;
            wb_in  = vic_dirty;
            if (vic_dirty && wbs_ff != 32'hFFFF_FFFF) begin
               wbs_in = wbs_ff + 32'd1;
            end
            for (int i = 0; i < F; i++) begin
               if (IDX_W'(i) >= victim) begin
                  cmd[i] = (i == F - 1) ? apr_pkg::CELL_LOAD : apr_pkg::CELL_TAKE;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (tick_ff == interval_ff) begin
                  tick_in = 8'd0;
                  for (int i = 0; i < F; i++) begin
                     cmd[i] = apr_pkg::CELL_SHIFT;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= apr_pkg::SHIFT_RESET;
         bits_ff      <= apr_pkg::BITS_RESET;
         tick_ff      <= '0;
         used_ff      <= '0;
         faults_ff    <= '0;
         wbs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         bits_ff      <= bits_in;
         tick_ff      <= tick_in;
         used_ff      <= used_in;
         faults_ff    <= faults_in;
         wbs_ff       <= wbs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      wr_ff   <= wr_in;
      cand_ff <= cand_in;
      grp_ff  <= grp_in;
      hit_ff  <= hit_in;
      evv_ff  <= evv_in;
      evp_ff  <= evp_in;
      wb_ff   <= wb_in;
      if (state_ff == ST_FINISH && rsp_load) begin
         rsp_hit_ff    <= hit_ff;
         rsp_evv_ff    <= evv_ff;
         rsp_evp_ff    <= evp_ff;
         rsp_wb_ff     <= wb_ff;
         rsp_faults_ff <= faults_ff;
         rsp_wbs_ff    <= wbs_ff;
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_evicted_valid   = rsp_evv_ff;
   assign rsp_evicted_page    = rsp_evp_ff;
   assign rsp_write_back      = rsp_wb_ff;
   assign rsp_fault_total     = rsp_faults_ff;
   assign rsp_writeback_total = rsp_wbs_ff;
endmodule
`default_nettype wire

### sv/apr_cell.sv
// One frame of the replacement row: page, dirty mark and age register.
// Takes its upper neighbor's entry when the row closes up after an eviction.
// Depends on apr_pkg.
`default_nettype none
module apr_cell (
   input  wire logic                    clock,
   input  wire apr_pkg::cell_cmd_type   cmd,
   input  wire apr_pkg::cell_bus_type   bus,
   input  wire apr_pkg::cell_entry_type upper,
   input  wire logic                    valid,
   output apr_pkg::cell_entry_type      entry,
   output logic                         match
);
   apr_pkg::cell_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd)
         apr_pkg::CELL_LOAD: begin
            entry_in.page  = bus.page;
            entry_in.dirty = bus.wr;
            entry_in.age   = bus.top;
         end
         apr_pkg::CELL_TAKE: entry_in = upper;
         apr_pkg::CELL_HIT: begin
            entry_in.dirty = entry_ff.dirty | bus.wr;
            entry_in.age   = entry_ff.age | bus.top;
         end
         apr_pkg::CELL_SHIFT: entry_in.age = (entry_ff.age >> 1) & bus.amask;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = valid && (entry_ff.page == bus.page);
endmodule
`default_nettype wire

### tb/aging_page_replacement_checker.sv
`timescale 1ns / 100ps
// Checker for the aging page replacement block: it watches the request, result and
// configuration channels, keeps its own copy of the frame table and compares results.
// Depends on apr_pkg.
module aging_page_replacement_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [apr_pkg::PAGE_BITS-1:0] req_page_number,
   input  wire logic                          req_write_access,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          rsp_hit,
   input  wire logic                          rsp_evicted_valid,
   input  wire logic [apr_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   input  wire logic                          rsp_write_back,
   input  wire logic [31:0]                   rsp_fault_total,
   input  wire logic [31:0]                   rsp_writeback_total,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [7:0]                    csr_index,
   input  wire logic [7:0]                    csr_wdata,
   output int                                 error_count,
   output int                                 pending_count
);
   import apr_pkg::*;

   typedef struct packed {
      logic                 hit;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic                 write_back;
      logic [31:0]          fault_total;
      logic [31:0]          writeback_total;
   } lookup_result_type;

   logic [PAGE_BITS-1:0] page_of [FRAMES];
   logic                 dirty_of[FRAMES];
   logic [31:0]          age_of  [FRAMES];
   int                   rank_of [FRAMES];
   int                   used_frames;
   logic [7:0]           ref_ticks;
   logic [31:0]          fault_count;
   logic [31:0]          wb_count;
   logic [7:0]           interval_cfg;
   logic [5:0]           width_cfg;
   lookup_result_type    expected_results[$];

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic reference_page(input logic [PAGE_BITS-1:0] page, input logic wr,
                                 output lookup_result_type r);
      int          n;
      int          slot;
      int          best;
      int          victim_rank;
      logic [31:0] top;
      logic [31:0] amask;
      n = (width_cfg == 0) ? 1 : (width_cfg > 32) ? 32 : width_cfg;
      top = 32'd1 << (n - 1);
      amask = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      r = '0;
      slot = -1;
      ref_ticks = ref_ticks + 8'd1;
      for (int i = 0; i < used_frames; i++) begin
         if (slot < 0 && page_of[i] == page) slot = i;
      end
      if (slot >= 0) begin
         r.hit = 1'b1;
         dirty_of[slot] = dirty_of[slot] | wr;
         age_of[slot] = age_of[slot] | top;
      end else begin
         fault_count = bump(fault_count);
         if (used_frames < FRAMES) begin
            page_of[used_frames] = page;
            dirty_of[used_frames] = wr;
            age_of[used_frames] = top;
            rank_of[used_frames] = used_frames;
            used_frames++;
         end else begin
            best = 0;
            for (int i = 1; i < FRAMES; i++) begin
               if (age_of[i] < age_of[best] ||
                   (age_of[i] == age_of[best] && rank_of[i] < rank_of[best])) best = i;
            end
            r.evicted_valid = 1'b1;
            r.evicted_page = page_of[best];
            if (dirty_of[best]) begin
               r.write_back = 1'b1;
               wb_count = bump(wb_count);
            end
            victim_rank = rank_of[best];
            for (int i = 0; i < FRAMES; i++) begin
               if (rank_of[i] > victim_rank) rank_of[i]--;
            end
            page_of[best] = page;
            dirty_of[best] = wr;
            age_of[best] = top;
            rank_of[best] = FRAMES - 1;
         end
      end
      if (ref_ticks == interval_cfg) begin
         for (int i = 0; i < used_frames; i++) age_of[i] = (age_of[i] >> 1) & amask;
         ref_ticks = 8'd0;
      end
      r.fault_total = fault_count;
      r.writeback_total = wb_count;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         used_frames = 0;
         ref_ticks = 8'd0;
         fault_count = '0;
         wb_count = '0;
         interval_cfg = SHIFT_RESET;
         width_cfg = BITS_RESET;
         expected_results.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SHIFT_INTERVAL) interval_cfg = csr_wdata;
            else if (csr_index == CSR_REGISTER_BITS) width_cfg = csr_wdata[5:0];
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hit, rsp_evicted_valid, rsp_evicted_page, rsp_write_back,
                    rsp_fault_total, rsp_writeback_total};
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected", $time);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("hit", want.hit, got.hit);
               compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
               compare_field("evicted_page", want.evicted_page, got.evicted_page);
               compare_field("write_back", want.write_back, got.write_back);
               compare_field("fault_total", want.fault_total, got.fault_total);
               compare_field("writeback_total", want.writeback_total, got.writeback_total);
            end
         end
         if (req_valid && req_ready) begin
            reference_page(req_page_number, req_write_access, want);
            expected_results.push_back(want);
         end
      end
      pending_count = expected_results.size();
   end
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the aging page replacement testbench: clock, reset, reference and register
// stimulus, receiver stalls, watchdog and verdict. Depends on apr_pkg, the block and
// aging_page_replacement_checker.
module testbench;
   import apr_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic                 req_write_access = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic                 rsp_evicted_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic                 rsp_write_back;
   logic [31:0]          rsp_fault_total;
   logic [31:0]          rsp_writeback_total;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [7:0]           csr_index = '0;
   logic [7:0]           csr_wdata = '0;
   int                   error_count;
   int                   pending_count;
   int                   burst_left = 0;
   int                   stall_mode = 0;
   int                   idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   aging_page_replacement_top uut (.*);
   aging_page_replacement_checker checker_i (.*);

   // Receiver: the stall pattern changes at random.
   always @(posedge clock) begin
      if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(1);
         default: rsp_ready <= ($urandom_range(4) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic wr);
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         if ($urandom_range(2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_page_number <= page;
      req_write_access <= wr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // Leave a short quiet gap before the next phase.
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int pool);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (i == count / 2) drain();
         if (pick < 7) send_reference($urandom_range(pool - 1), $urandom_range(1));
         else if (pick < 8) send_reference(16'hFFFF - $urandom_range(pool - 1),
                                           $urandom_range(1));
         else send_reference($urandom, $urandom_range(1));
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme pages, hits with and without writes, then fill every frame
      // and evict while all ages sit at the maximum so insertion order decides.
      write_register(CSR_SHIFT_INTERVAL, 8'd200);
      write_register(CSR_REGISTER_BITS, 8'd63);
      send_reference(16'h0000, 1'b0);
      send_reference(16'hFFFF, 1'b1);
      send_reference(16'h0000, 1'b1);
      send_reference(16'hFFFF, 1'b0);
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'h5555, 1'b1);
      for (int p = 1; p < FRAMES; p++) send_reference(16'h0100 + p, p[0]);
      send_reference(16'h1234, 1'b0);
      send_reference(16'h4321, 1'b1);
      send_reference(16'hFFFF, 1'b0);
      drain();

      write_register(CSR_REGISTER_BITS, 8'd0);
      write_register(CSR_SHIFT_INTERVAL, 8'd1);
      random_phase(250, 80);
      write_register(CSR_REGISTER_BITS, 8'd32);
      write_register(CSR_SHIFT_INTERVAL, 8'd255);
      random_phase(250, 96);
      // Interval zero: the tick counter wraps, so shifts come every 256 references.
      write_register(CSR_SHIFT_INTERVAL, 8'd0);
      write_register(CSR_REGISTER_BITS, 8'd4);
      random_phase(250, 72);
      write_register(CSR_SHIFT_INTERVAL, 8'd3);
      write_register(CSR_REGISTER_BITS, 8'd1);
      random_phase(250, 70);
      write_register(CSR_SHIFT_INTERVAL, 8'd10);
      write_register(CSR_REGISTER_BITS, 8'd8);
      random_phase(250, 90);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
